### rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM byte access master.
package i2cee_pkg;

  // Request codes carried by a command item
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Reset value of the seven-bit device address register
  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

  // R/W bit of the device byte
  localparam logic DEV_RW_WRITE = 1'b0;
  localparam logic DEV_RW_READ  = 1'b1;

  // Sequencer steps of one transaction
  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_DEV     = 4'd2,
    ST_AHI     = 4'd3,
    ST_ALO     = 4'd4,
    ST_DATA    = 4'd5,
    ST_STOP    = 4'd6,
    ST_RESTART = 4'd7,
    ST_DEVRD   = 4'd8,
    ST_READ    = 4'd9
  } step_e;

endpackage

### rtl/i2cee_if.sv
// Channel interfaces: command items, result items and the address register write.
interface i2cee_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] mem_addr;
  logic [7:0]  wr_data;
  logic        sda_in;

  modport source (output valid, req_type, mem_addr, wr_data, sda_in, input ready);
  modport sink   (input valid, req_type, mem_addr, wr_data, sda_in, output ready);
endinterface

interface i2cee_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic       ack_ok;
  logic [7:0] read_byte;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, ack_ok,
                  read_byte, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, ack_ok,
                  read_byte, output ready);
endinterface

interface i2cee_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/i2c_eeprom_byte_access_master.sv
// I2C master for single-byte write and random read of a 24Cxx EEPROM.
//
//   channel  | dir | payload                                         | accepted when
//   ---------+-----+-------------------------------------------------+------------------
//   cmd_i    | in  | req_type, mem_addr, wr_data, sda_in             | valid && ready
//   res_o    | out | scl_level, sda_release, busy_res, done_res,     | valid && ready
//            |     | ack_ok, read_byte                               |
//   cfg_i    | in  | data (seven-bit device address)                 | valid && ready
//
// Each item yields a result item in the cycle after it is accepted; one item per cycle
// while res_o keeps up. The sequencer moves one bus phase per accepted item.
// cmd_i.ready is high while the result register is empty or being emptied.
// cfg_i.ready is always high. Reset returns to idle with both lines released.
module i2c_eeprom_byte_access_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cee_cmd_if.sink   cmd_i,
  i2cee_cfg_if.sink   cfg_i,
  i2cee_res_if.source res_o
);

  // Sequencer state
  i2cee_pkg::step_e step_q, step_d;
  logic             phase_q, phase_d;   // 0 = SCL high phase, 1 = SCL low phase
  logic [3:0]       bitcnt_q, bitcnt_d;
  logic [7:0]       shift_q, shift_d;
  logic [15:0]      addr_q, addr_d;
  logic [7:0]       data_q, data_d;
  logic             rd_q, rd_d;
  logic             nack_q, nack_d;
  logic [1:0]       line_q;             // {scl, sda} held while idle
  logic [6:0]       dev_q;

  // Result register
  logic       res_valid_q;
  logic       res_scl_q, res_sda_q, res_busy_q, res_done_q, res_ok_q;
  logic [7:0] res_byte_q;

  // Phase outputs
  logic       scl_c, sda_c, done_c, ok_c;
  logic [7:0] rbyte_c;

  logic acc, high;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;
  assign high        = !phase_q;

  // Byte to shift out on entering a step
  function automatic logic [7:0] load_byte(i2cee_pkg::step_e nxt, logic [6:0] dev,
                                           logic [15:0] addr, logic [7:0] data,
                                           logic [7:0] keep);
    logic [7:0] b;
    case (nxt)
      i2cee_pkg::ST_DEV:   b = {dev, i2cee_pkg::DEV_RW_WRITE};
      i2cee_pkg::ST_DEVRD: b = {dev, i2cee_pkg::DEV_RW_READ};
      i2cee_pkg::ST_AHI:   b = addr[15:8];
      i2cee_pkg::ST_ALO:   b = addr[7:0];
      i2cee_pkg::ST_DATA:  b = data;
      i2cee_pkg::ST_READ:  b = 8'h00;
      default:             b = keep;
    endcase
    return b;
  endfunction

  // Next state of the sequencer for one item
  always_comb begin
    i2cee_pkg::step_e nxt;
    step_d   = step_q;
    phase_d  = phase_q;
    bitcnt_d = bitcnt_q;
    shift_d  = shift_q;
    addr_d   = addr_q;
    data_d   = data_q;
    rd_d     = rd_q;
    nack_d   = nack_q;
    nxt      = i2cee_pkg::ST_STOP;
    if (step_q == i2cee_pkg::ST_IDLE) begin
      if (cmd_i.req_type == i2cee_pkg::REQ_WRITE || cmd_i.req_type == i2cee_pkg::REQ_READ) begin
        addr_d   = cmd_i.mem_addr;
        data_d   = cmd_i.wr_data;
        rd_d     = (cmd_i.req_type == i2cee_pkg::REQ_READ);
        nack_d   = 1'b0;
        phase_d  = 1'b0;
        step_d   = i2cee_pkg::ST_START;
        bitcnt_d = 4'd0;
      end
    end else begin
      case (step_q)
        i2cee_pkg::ST_START, i2cee_pkg::ST_RESTART: begin
          if (!high) begin
            nxt      = (step_q == i2cee_pkg::ST_START) ? i2cee_pkg::ST_DEV
                                                       : i2cee_pkg::ST_DEVRD;
            step_d   = nxt;
            bitcnt_d = 4'd0;
            shift_d  = load_byte(nxt, dev_q, addr_q, data_q, shift_q);
          end
        end
        i2cee_pkg::ST_DEV, i2cee_pkg::ST_AHI, i2cee_pkg::ST_ALO,
        i2cee_pkg::ST_DATA, i2cee_pkg::ST_DEVRD: begin
          if (!bitcnt_q[3]) begin
            // Shift out the next bit at the end of its low phase
            if (!high) begin
              shift_d  = {shift_q[6:0], 1'b0};
              bitcnt_d = bitcnt_q + 4'd1;
            end
          end else if (high) begin
            // Sample the ACK; only a write keeps a NACK
            if (cmd_i.sda_in && !rd_q) nack_d = 1'b1;
          end else begin
            case (step_q)
              i2cee_pkg::ST_DEV:   nxt = i2cee_pkg::ST_AHI;
              i2cee_pkg::ST_AHI:   nxt = i2cee_pkg::ST_ALO;
              i2cee_pkg::ST_ALO:   nxt = rd_q ? i2cee_pkg::ST_RESTART : i2cee_pkg::ST_DATA;
              i2cee_pkg::ST_DEVRD: nxt = i2cee_pkg::ST_READ;
              default:             nxt = i2cee_pkg::ST_STOP;
            endcase
            step_d   = nxt;
            bitcnt_d = 4'd0;
            shift_d  = load_byte(nxt, dev_q, addr_q, data_q, shift_q);
          end
        end
        i2cee_pkg::ST_READ: begin
          if (!bitcnt_q[3]) begin
            if (high) shift_d  = {shift_q[6:0], cmd_i.sda_in};
            else      bitcnt_d = bitcnt_q + 4'd1;
          end else if (!high) begin
            step_d   = i2cee_pkg::ST_STOP;
            bitcnt_d = 4'd0;
          end
        end
        i2cee_pkg::ST_STOP: begin
          if (!high) begin
            step_d   = i2cee_pkg::ST_IDLE;
            bitcnt_d = 4'd0;
          end
        end
        default: step_d = i2cee_pkg::ST_IDLE;
      endcase
      phase_d = (step_d == i2cee_pkg::ST_IDLE) ? 1'b0 : !phase_q;
    end
  end

  // Line levels and completion flags for the current phase
  always_comb begin
    scl_c   = 1'b1;
    sda_c   = 1'b1;
    done_c  = 1'b0;
    ok_c    = 1'b0;
    rbyte_c = 8'h00;
    case (step_q)
      i2cee_pkg::ST_IDLE: begin
        scl_c = line_q[1];
        sda_c = line_q[0];
      end
      i2cee_pkg::ST_START, i2cee_pkg::ST_RESTART: begin
        sda_c = high;
      end
      i2cee_pkg::ST_DEV, i2cee_pkg::ST_AHI, i2cee_pkg::ST_ALO,
      i2cee_pkg::ST_DATA, i2cee_pkg::ST_DEVRD: begin
        scl_c = high;
        sda_c = bitcnt_q[3] ? 1'b1 : shift_q[7];
      end
      i2cee_pkg::ST_READ: begin
        scl_c = high;
      end
      i2cee_pkg::ST_STOP: begin
        sda_c = !high;
        if (!high) begin
          done_c  = 1'b1;
          ok_c    = rd_q || !nack_q;
          rbyte_c = rd_q ? shift_q : 8'h00;
        end
      end
      default: begin
        scl_c = 1'b1;
        sda_c = 1'b1;
      end
    endcase
  end

  // Advance the sequencer on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= i2cee_pkg::ST_IDLE;
      phase_q  <= 1'b0;
      bitcnt_q <= 4'd0;
      shift_q  <= 8'h00;
      addr_q   <= 16'h0000;
      data_q   <= 8'h00;
      rd_q     <= 1'b0;
      nack_q   <= 1'b0;
      line_q   <= 2'b11;
    end else if (acc) begin
      step_q   <= step_d;
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      shift_q  <= shift_d;
      addr_q   <= addr_d;
      data_q   <= data_d;
      rd_q     <= rd_d;
      nack_q   <= nack_d;
      if (step_q != i2cee_pkg::ST_IDLE) line_q <= {scl_c, sda_c};
    end
  end

  // Take the device address write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= i2cee_pkg::DEV_ADDR_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      dev_q <= cfg_i.data;
    end
  end

  // Hold the result item until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_scl_q  <= scl_c;
      res_sda_q  <= sda_c;
      res_busy_q <= (step_d != i2cee_pkg::ST_IDLE);
      res_done_q <= done_c;
      res_ok_q   <= ok_c;
      res_byte_q <= rbyte_c;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.scl_level   = res_scl_q;
  assign res_o.sda_release = res_sda_q;
  assign res_o.busy_res    = res_busy_q;
  assign res_o.done_res    = res_done_q;
  assign res_o.ack_ok      = res_ok_q;
  assign res_o.read_byte   = res_byte_q;

`ifndef NO_ASSERTIONS
  // Idle leaves no phase or bit count behind
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == i2cee_pkg::ST_IDLE |-> phase_q == 1'b0 && bitcnt_q == 4'd0)
    else $error("idle with stale phase or bit count");

  // Bit count never passes the ACK slot
  a_bitcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitcnt_q <= 4'd8)
    else $error("bit count out of range");

  // A completing item returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && done_c |=> step_q == i2cee_pkg::ST_IDLE)
    else $error("stop completed but sequencer not idle");

  // Completion flags stay clear without done
  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_done_q |-> !res_ok_q && res_byte_q == 8'h00)
    else $error("ack_ok or read_byte set without done");

  // A write never returns a read byte
  a_write_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && done_c && !rd_q |-> rbyte_c == 8'h00)
    else $error("read byte reported after a write");
`endif

endmodule

### tb/sv/tb_i2c_eeprom_byte_access_master.sv
// Self-checking testbench: bus phase prediction and checking of the I2C EEPROM byte master.
module tb_i2c_eeprom_byte_access_master;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_PERIOD     = 12;
  localparam int         STALL_LIMIT    = 4000;
  localparam int         HOLDOFF_CYCLES = 400;
  localparam int         PHASE_ITEMS    = 350;
  // Spare request code, handled by the block as a tick
  localparam logic [1:0] REQ_SPARE      = 2'd3;

  // One bus phase as seen on the result channel
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       ok;
    logic [7:0] rbyte;
  } bus_phase_t;

  // Bus sequencer mirror and store of the phases it predicts
  class bus_phase_scoreboard;
    logic [6:0]       dev_addr;
    i2cee_pkg::step_e step;
    logic             low_phase;
    logic [3:0]       nbits;
    logic [7:0]       shreg;
    logic [15:0]      addr_q;
    logic [7:0]       data_q;
    logic             rd_q;
    logic             nack;
    logic             scl_q;
    logic             sda_q;
    bus_phase_t       expected_phases[$];
    int               errors;

    function new();
      dev_addr  = i2cee_pkg::DEV_ADDR_RESET;
      step      = i2cee_pkg::ST_IDLE;
      low_phase = 1'b0;
      nbits     = '0;
      shreg     = '0;
      addr_q    = '0;
      data_q    = '0;
      rd_q      = 1'b0;
      nack      = 1'b0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      errors    = 0;
    endfunction

    function void write_dev_addr(input logic [6:0] value);
      dev_addr = value;
    endfunction

    function bit busy();
      return step != i2cee_pkg::ST_IDLE;
    endfunction

    function int pending();
      return expected_phases.size();
    endfunction

    // Enter a step and load the byte it shifts out
    function void load_step(input i2cee_pkg::step_e next);
      step  = next;
      nbits = '0;
      case (next)
        i2cee_pkg::ST_DEV:   shreg = {dev_addr, i2cee_pkg::DEV_RW_WRITE};
        i2cee_pkg::ST_DEVRD: shreg = {dev_addr, i2cee_pkg::DEV_RW_READ};
        i2cee_pkg::ST_AHI:   shreg = addr_q[15:8];
        i2cee_pkg::ST_ALO:   shreg = addr_q[7:0];
        i2cee_pkg::ST_DATA:  shreg = data_q;
        i2cee_pkg::ST_READ:  shreg = '0;
        default: ;
      endcase
    endfunction

    function i2cee_pkg::step_e step_after_byte(input i2cee_pkg::step_e s);
      case (s)
        i2cee_pkg::ST_DEV:   return i2cee_pkg::ST_AHI;
        i2cee_pkg::ST_AHI:   return i2cee_pkg::ST_ALO;
        i2cee_pkg::ST_ALO:   return rd_q ? i2cee_pkg::ST_RESTART : i2cee_pkg::ST_DATA;
        i2cee_pkg::ST_DEVRD: return i2cee_pkg::ST_READ;
        default:             return i2cee_pkg::ST_STOP;
      endcase
    endfunction

    // Advance the sequencer by one accepted item and note the phase it gives
    function void predict_phase(input logic [1:0] req, input logic [15:0] addr,
                                input logic [7:0] data, input logic sda_in);
      bus_phase_t r;
      logic       high;
      logic       scl;
      logic       sda;
      r    = '0;
      high = !low_phase;
      scl  = 1'b1;
      sda  = 1'b1;
      if (step == i2cee_pkg::ST_IDLE) begin
        if (req == i2cee_pkg::REQ_WRITE || req == i2cee_pkg::REQ_READ) begin
          addr_q    = addr;
          data_q    = data;
          rd_q      = (req == i2cee_pkg::REQ_READ);
          nack      = 1'b0;
          low_phase = 1'b0;
          load_step(i2cee_pkg::ST_START);
        end
        r.scl  = scl_q;
        r.sda  = sda_q;
        r.busy = busy();
        expected_phases.push_back(r);
        return;
      end
      case (step)
        i2cee_pkg::ST_START, i2cee_pkg::ST_RESTART: begin
          sda = high;
          if (!high) begin
            if (step == i2cee_pkg::ST_START) load_step(i2cee_pkg::ST_DEV);
            else load_step(i2cee_pkg::ST_DEVRD);
          end
        end
        i2cee_pkg::ST_DEV, i2cee_pkg::ST_AHI, i2cee_pkg::ST_ALO,
        i2cee_pkg::ST_DATA, i2cee_pkg::ST_DEVRD: begin
          scl = high;
          if (nbits < 4'd8) begin
            sda = shreg[7];
            if (!high) begin
              shreg = shreg << 1;
              nbits = nbits + 4'd1;
            end
          end else if (high) begin
            // ACK slot: only a write records a missing acknowledge
            if (sda_in && !rd_q) nack = 1'b1;
          end else begin
            load_step(step_after_byte(step));
          end
        end
        i2cee_pkg::ST_READ: begin
          scl = high;
          if (nbits < 4'd8) begin
            if (high) shreg = {shreg[6:0], sda_in};
            else nbits = nbits + 4'd1;
          end else if (!high) begin
            step  = i2cee_pkg::ST_STOP;
            nbits = '0;
          end
        end
        i2cee_pkg::ST_STOP: begin
          sda = !high;
          if (!high) begin
            r.done = 1'b1;
            r.ok   = rd_q ? 1'b1 : !nack;
            r.rbyte = rd_q ? shreg : 8'd0;
            step   = i2cee_pkg::ST_IDLE;
            nbits  = '0;
          end
        end
        default: step = i2cee_pkg::ST_IDLE;
      endcase
      low_phase = !low_phase;
      if (step == i2cee_pkg::ST_IDLE) low_phase = 1'b0;
      scl_q  = scl;
      sda_q  = sda;
      r.scl  = scl;
      r.sda  = sda;
      r.busy = busy();
      expected_phases.push_back(r);
    endfunction

    function void compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare a result item with the oldest predicted phase
    function void check_phase(input bus_phase_t act);
      bus_phase_t exp_p;
      if (expected_phases.size() == 0) begin
        $error("result item with no prediction waiting");
        errors++;
        return;
      end
      exp_p = expected_phases.pop_front();
      compare_field("scl_level", exp_p.scl, act.scl);
      compare_field("sda_release", exp_p.sda, act.sda);
      compare_field("busy_res", exp_p.busy, act.busy);
      compare_field("done_res", exp_p.done, act.done);
      compare_field("ack_ok", exp_p.ok, act.ok);
      compare_field("read_byte", exp_p.rbyte, act.rbyte);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  i2cee_cmd_if cmd ();
  i2cee_res_if res ();
  i2cee_cfg_if cfg ();

  i2c_eeprom_byte_access_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  bus_phase_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit holdoff_req    = 1'b0;
  int holdoff_left   = 0;
  bit ack_low_bias   = 1'b1;
  int stall_cycles   = 0;

  // Toggle the clock every half period
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Note accepted items and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) sb.write_dev_addr(cfg.data);
      if (cmd.valid && cmd.ready)
        sb.predict_phase(cmd.req_type, cmd.mem_addr, cmd.wr_data, cmd.sda_in);
      if (res.valid && res.ready)
        sb.check_phase({res.scl_level, res.sda_release, res.busy_res, res.done_res,
                        res.ack_ok, res.read_byte});
    end
  end

  // Drop the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_i2c_eeprom_byte_access_master: FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
        res.ready = 1'b0;
        holdoff_left--;
      end else begin
        res.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one command item, with random idle cycles ahead of it; return at a falling edge
  task automatic offer_item(input logic [1:0] req, input logic [15:0] addr,
                            input logic [7:0] data, input logic sda);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd.valid    = 1'b1;
    cmd.req_type = req;
    cmd.mem_addr = addr;
    cmd.wr_data  = data;
    cmd.sda_in   = sda;
    do @(posedge clk_i); while (!cmd.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    cmd.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_dev_addr(input logic [6:0] value);
    wait_drained();
    repeat (3) @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.data  = value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // Tick the bus with a fixed SDA level until the transaction ends
  task automatic run_to_idle(input logic sda);
    while (sb.busy()) offer_item(i2cee_pkg::REQ_TICK, 16'h0000, 8'h00, sda);
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random item: mostly well-formed transactions, some noise
  task automatic random_item();
    logic [1:0]  req;
    logic        sda;
    if (!sb.busy()) begin
      case ($urandom_range(11))
        0:       req = i2cee_pkg::REQ_TICK;
        1:       req = REQ_SPARE;
        default: req = $urandom_range(1) ? i2cee_pkg::REQ_READ : i2cee_pkg::REQ_WRITE;
      endcase
      ack_low_bias = ($urandom_range(3) != 0);
      sda = 1'($urandom);
    end else begin
      req = ($urandom_range(19) == 0) ? 2'($urandom_range(3)) : i2cee_pkg::REQ_TICK;
      sda = ack_low_bias ? ($urandom_range(19) == 0) : 1'($urandom);
    end
    offer_item(req, pick_addr(), 8'($urandom), sda);
  endtask

  initial begin
    cmd.valid    = 1'b0;
    cmd.req_type = i2cee_pkg::REQ_TICK;
    cmd.mem_addr = '0;
    cmd.wr_data  = '0;
    cmd.sda_in   = 1'b1;
    cfg.valid    = 1'b0;
    cfg.data     = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: idle ticks, commands while busy, full ACK, missing ACK, read of all ones
    offer_item(i2cee_pkg::REQ_TICK, 16'hFFFF, 8'hFF, 1'b1);
    offer_item(REQ_SPARE, 16'h0000, 8'h00, 1'b0);
    offer_item(i2cee_pkg::REQ_WRITE, 16'hFFFF, 8'hFF, 1'b0);
    offer_item(i2cee_pkg::REQ_WRITE, 16'h0000, 8'h00, 1'b0);
    offer_item(i2cee_pkg::REQ_READ, 16'hFFFF, 8'hFF, 1'b1);
    offer_item(REQ_SPARE, 16'hA5A5, 8'h5A, 1'b0);
    run_to_idle(1'b0);
    offer_item(i2cee_pkg::REQ_READ, 16'h0000, 8'h00, 1'b0);
    run_to_idle(1'b1);
    offer_item(i2cee_pkg::REQ_READ, 16'hFFFF, 8'hFF, 1'b0);
    run_to_idle(1'b0);
    offer_item(i2cee_pkg::REQ_WRITE, 16'h0000, 8'h00, 1'b1);
    run_to_idle(1'b1);

    // Random phases with their own idling and device address
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  write_dev_addr(7'h7F);
          holdoff_req = 1'b1;
        end
        1: begin
          send_idle_pct = 79; recv_stall_pct = 0;  write_dev_addr(7'h00);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 79; write_dev_addr(7'($urandom));
        end
        default: begin
          send_idle_pct = 8;  recv_stall_pct = 8;
          write_dev_addr(i2cee_pkg::DEV_ADDR_RESET);
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Pause the sender until the result channel has caught up
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_i2c_eeprom_byte_access_master: PASS");
    end else begin
      $display("tb_i2c_eeprom_byte_access_master: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/i2cee_pkg.sv
rtl/i2cee_if.sv
rtl/i2c_eeprom_byte_access_master.sv
tb/sv/tb_i2c_eeprom_byte_access_master.sv
